>>> src/tarp_pkg.sv
`default_nettype none

package tarp_pkg;

    // Words that the file format fixes.
    localparam logic [31:0] MAGIC_WORD   = 32'd10000;
    localparam logic [31:0] VERSION_WORD = 32'd10000;
    localparam logic [31:0] TAG_NAME     = 32'd10100;
    localparam logic [31:0] TAG_SETS     = 32'd20000;
    localparam logic [31:0] TAG_PATTERNS = 32'd30000;
    localparam logic [31:0] KEY_FIRST    = 32'd30100;
    localparam logic [31:0] KEY_LAST     = 32'd30105;
    localparam logic [31:0] TAG_END      = 32'd999999;

    // Number of key/value fields in one frame; the wait time sits at WAIT_FIELD.
    localparam int NUM_FIELDS = 6;
    localparam logic [2:0] WAIT_FIELD = 3'd3;

    // Result kinds.
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_VERSION   = 3'd2;
    localparam logic [2:0] ERR_HEADER    = 3'd3;
    localparam logic [2:0] ERR_COUNT_TAG = 3'd4;
    localparam logic [2:0] ERR_PATTERN   = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;

    // Result queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NUM_FIELDS-1:0][31:0] frame_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [30:0] set_idx;
        logic [30:0] pat_idx;
        frame_t      fields;
        logic [31:0] elapsed;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

>>> src/tagged_animation_record_parser_unit.sv
// Results: the results of a request are written into the result queue and offered from its head in order.
// Throughput: one byte per cycle while in_stall is low; a byte yields up to two results, which
// leave through a four-entry result queue at one per cycle while out_stall is low, and input
// stall rises while fewer than two entries are free.
// Reset: rst_n is asynchronous and active low; the parser waits for the magic word and
// the result queue is empty.
`default_nettype none

module tagged_animation_record_parser_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_file,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              kind,
    output logic [2:0]              error_code,
    output logic [30:0]             set_index,
    output logic [30:0]             pattern_index,
    output logic signed [31:0]      pattern_number,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      wait_time,
    output logic signed [31:0]      blend_value,
    output logic signed [31:0]      depth_z,
    output logic signed [31:0]      elapsed_time,
    output logic                    last_in_run
);
    import tarp_pkg::*;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_VERSION,
        PH_HEADER,
        PH_NAME_LEN,
        PH_NAME_SKIP,
        PH_SET_COUNT,
        PH_COUNT_TAG,
        PH_PAT_COUNT,
        PH_KEY,
        PH_VALUE,
        PH_DROP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] word_reg, word_next;
    logic [1:0]  byte_phase_reg, byte_phase_next;
    logic [2:0]  key_reg, key_next;
    logic [30:0] name_left_reg, name_left_next;
    logic [30:0] sets_left_reg, sets_left_next;
    logic [30:0] pats_left_reg, pats_left_next;
    logic [30:0] cur_set_reg, cur_set_next;
    logic [30:0] cur_pat_reg, cur_pat_next;
    frame_t      fields_reg, fields_next;
    logic [31:0] elapsed_reg, elapsed_next;

    result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    logic        accept;
    logic        pop;
    logic [31:0] word;
    logic [31:0] key_offset;
    logic [31:0] elapsed_sum;
    logic        rec_ev, status_ev, end_set_ev, trunc_ev;
    logic [1:0]  status_kind;
    logic [2:0]  status_err;
    result_t     res0, res1, status_res, trunc_res;
    logic [1:0]  num_res;
    result_t     head;

    assign accept      = in_valid && !in_stall;
    assign pop         = out_valid && !out_stall;
    assign word        = {data_byte, word_reg};
    assign key_offset  = word - KEY_FIRST;
    assign elapsed_sum = elapsed_reg + fields_reg[WAIT_FIELD];

    // Byte assembly and parser step for one request.
    always_comb
    begin
        phase_next      = phase_reg;
        word_next       = word_reg;
        byte_phase_next = byte_phase_reg;
        key_next        = key_reg;
        name_left_next  = name_left_reg;
        sets_left_next  = sets_left_reg;
        pats_left_next  = pats_left_reg;
        cur_set_next    = cur_set_reg;
        cur_pat_next    = cur_pat_reg;
        fields_next     = fields_reg;
        elapsed_next    = elapsed_reg;
        rec_ev          = 1'b0;
        status_ev       = 1'b0;
        status_kind     = KIND_ERROR;
        status_err      = ERR_NONE;
        end_set_ev      = 1'b0;
        trunc_ev        = 1'b0;

        if (accept)
        begin
            if (phase_reg == PH_DROP)
            begin
                // The rest of the file is ignored.
            end
            else if (phase_reg == PH_NAME_SKIP)
            begin
                name_left_next = name_left_reg - 31'd1;
                if (name_left_reg == 31'd1)
                begin
                    phase_next = PH_HEADER;
                end
            end
            else if (byte_phase_reg != 2'd3)
            begin
                case (byte_phase_reg)
                    2'd0:    word_next[7:0]   = data_byte;
                    2'd1:    word_next[15:8]  = data_byte;
                    default: word_next[23:16] = data_byte;
                endcase
                byte_phase_next = byte_phase_reg + 2'd1;
            end
            else
            begin
                // A full little-endian word is present.
                word_next       = '0;
                byte_phase_next = 2'd0;
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (word != MAGIC_WORD)
                        begin
                            status_ev  = 1'b1;
                            status_err = ERR_MAGIC;
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            phase_next = PH_VERSION;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (word != VERSION_WORD)
                        begin
                            status_ev  = 1'b1;
                            status_err = ERR_VERSION;
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (word == TAG_NAME)
                        begin
                            phase_next = PH_NAME_LEN;
                        end
                        else if (word == TAG_SETS)
                        begin
                            phase_next = PH_SET_COUNT;
                        end
                        else
                        begin
                            status_ev  = 1'b1;
                            status_err = ERR_HEADER;
                            phase_next = PH_DROP;
                        end
                    end
                    PH_NAME_LEN:
                    begin
                        if (word[31])
                        begin
                            status_ev  = 1'b1;
                            status_err = ERR_HEADER;
                            phase_next = PH_DROP;
                        end
                        else if (word == 32'd0)
                        begin
                            phase_next = PH_HEADER;
                        end
                        else
                        begin
                            name_left_next = word[30:0];
                            phase_next     = PH_NAME_SKIP;
                        end
                    end
                    PH_SET_COUNT:
                    begin
                        cur_set_next = '0;
                        if (word[31] || word == 32'd0)
                        begin
                            status_ev   = 1'b1;
                            status_kind = KIND_DONE;
                            phase_next  = PH_DROP;
                        end
                        else
                        begin
                            sets_left_next = word[30:0];
                            elapsed_next   = '0;
                            phase_next     = PH_COUNT_TAG;
                        end
                    end
                    PH_COUNT_TAG:
                    begin
                        if (word != TAG_PATTERNS)
                        begin
                            status_ev  = 1'b1;
                            status_err = ERR_COUNT_TAG;
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            phase_next = PH_PAT_COUNT;
                        end
                    end
                    PH_PAT_COUNT:
                    begin
                        cur_pat_next = '0;
                        fields_next  = '0;
                        if (word[31] || word == 32'd0)
                        begin
                            end_set_ev = 1'b1;
                        end
                        else
                        begin
                            pats_left_next = word[30:0];
                            phase_next     = PH_KEY;
                        end
                    end
                    PH_KEY:
                    begin
                        if (word == TAG_END)
                        begin
                            rec_ev         = 1'b1;
                            elapsed_next   = elapsed_sum;
                            fields_next    = '0;
                            cur_pat_next   = cur_pat_reg + 31'd1;
                            pats_left_next = pats_left_reg - 31'd1;
                            if (pats_left_reg == 31'd1)
                            begin
                                end_set_ev = 1'b1;
                            end
                        end
                        else if (word inside {[KEY_FIRST:KEY_LAST]})
                        begin
                            key_next   = key_offset[2:0];
                            phase_next = PH_VALUE;
                        end
                        else
                        begin
                            status_ev  = 1'b1;
                            status_err = ERR_PATTERN;
                            phase_next = PH_DROP;
                        end
                    end
                    PH_VALUE:
                    begin
                        fields_next[key_reg] = word;
                        phase_next           = PH_KEY;
                    end
                    default:
                    begin
                    end
                endcase

                // Closing a set: either the next set follows or the file is done.
                if (end_set_ev)
                begin
                    sets_left_next = sets_left_reg - 31'd1;
                    cur_set_next   = cur_set_reg + 31'd1;
                    if (sets_left_reg == 31'd1)
                    begin
                        status_ev   = 1'b1;
                        status_kind = KIND_DONE;
                        phase_next  = PH_DROP;
                    end
                    else
                    begin
                        elapsed_next = '0;
                        phase_next   = PH_COUNT_TAG;
                    end
                end
            end

            // End of file: report truncation if still parsing, then start over.
            if (end_of_file)
            begin
                trunc_ev        = (phase_next != PH_DROP);
                phase_next      = PH_MAGIC;
                word_next       = '0;
                byte_phase_next = 2'd0;
                key_next        = '0;
                name_left_next  = '0;
                sets_left_next  = '0;
                pats_left_next  = '0;
                cur_set_next    = '0;
                cur_pat_next    = '0;
                fields_next     = '0;
                elapsed_next    = '0;
            end
        end
    end

    // Order the results of this request: record first, then status, then truncation.
    always_comb
    begin
        status_res      = '0;
        status_res.kind = status_kind;
        status_res.err  = status_err;
        trunc_res       = '0;
        trunc_res.kind  = KIND_ERROR;
        trunc_res.err   = ERR_TRUNCATED;
        res0            = '0;
        res1            = '0;
        num_res         = 2'd0;

        if (rec_ev)
        begin
            res0.kind    = KIND_RECORD;
            res0.err     = ERR_NONE;
            res0.set_idx = cur_set_reg;
            res0.pat_idx = cur_pat_reg;
            res0.fields  = fields_reg;
            res0.elapsed = elapsed_sum;
            num_res      = 2'd1;
        end
        if (status_ev)
        begin
            if (num_res == 2'd0)
            begin
                res0 = status_res;
            end
            else
            begin
                res1 = status_res;
            end
            num_res = num_res + 2'd1;
        end
        if (trunc_ev)
        begin
            if (num_res == 2'd0)
            begin
                res0 = trunc_res;
            end
            else
            begin
                res1 = trunc_res;
            end
            num_res = num_res + 2'd1;
        end
        if (num_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (num_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            word_reg       <= '0;
            byte_phase_reg <= '0;
            key_reg        <= '0;
            name_left_reg  <= '0;
            sets_left_reg  <= '0;
            pats_left_reg  <= '0;
            cur_set_reg    <= '0;
            cur_pat_reg    <= '0;
            fields_reg     <= '0;
            elapsed_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            word_reg       <= word_next;
            byte_phase_reg <= byte_phase_next;
            key_reg        <= key_next;
            name_left_reg  <= name_left_next;
            sets_left_reg  <= sets_left_next;
            pats_left_reg  <= pats_left_next;
            cur_set_reg    <= cur_set_next;
            cur_pat_reg    <= cur_pat_next;
            fields_reg     <= fields_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(num_res);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(num_res) - QCNT_W'(pop);
        end
    end

    // Result queue entries.
    always_ff @(posedge clk)
    begin
        if (num_res != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (num_res == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    // Input is held off while fewer than two queue entries are free.
    assign in_stall  = (count_reg > QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = queue_reg[rd_ptr_reg];

    assign kind           = head.kind;
    assign error_code     = head.err;
    assign set_index      = head.set_idx;
    assign pattern_index  = head.pat_idx;
    assign pattern_number = $signed(head.fields[0]);
    assign pos_x          = $signed(head.fields[1]);
    assign pos_y          = $signed(head.fields[2]);
    assign wait_time      = $signed(head.fields[3]);
    assign blend_value    = $signed(head.fields[4]);
    assign depth_z        = $signed(head.fields[5]);
    assign elapsed_time   = $signed(head.elapsed);
    assign last_in_run    = head.last;

endmodule

`default_nettype wire

>>> src/tarp_checker.sv
`default_nettype none

module tarp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic [7:0]         data_byte,
    input wire logic               end_of_file,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         kind,
    input wire logic [2:0]         error_code,
    input wire logic [30:0]        set_index,
    input wire logic [30:0]        pattern_index,
    input wire logic signed [31:0] pattern_number,
    input wire logic signed [31:0] pos_x,
    input wire logic signed [31:0] pos_y,
    input wire logic signed [31:0] wait_time,
    input wire logic signed [31:0] blend_value,
    input wire logic signed [31:0] depth_z,
    input wire logic signed [31:0] elapsed_time,
    input wire logic               last_in_run
);
    import tarp_pkg::*;

    // A stalled request stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(end_of_file))
        else $error("stalled request changed");

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(error_code)
            && $stable(set_index) && $stable(pattern_index) && $stable(pattern_number)
            && $stable(pos_x) && $stable(pos_y) && $stable(wait_time)
            && $stable(blend_value) && $stable(depth_z) && $stable(elapsed_time)
            && $stable(last_in_run))
        else $error("stalled result changed");

    // Pattern records carry no error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RECORD |-> error_code == ERR_NONE)
        else $error("record with error code");

    // Done and error results close the request and carry zero indices and elapsed time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_RECORD |-> last_in_run && set_index == 31'd0
            && pattern_index == 31'd0 && elapsed_time == 32'sd0)
        else $error("status result not last or not cleared");

    // An error result always names its cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE)
        else $error("error result without code");

endmodule

bind tagged_animation_record_parser_unit tarp_checker u_tarp_checker (.*);

`default_nettype wire

>>> sim/tb_tagged_animation_record_parser_unit.sv
`default_nettype none

module tb_tagged_animation_record_parser_unit;
    import tarp_pkg::*;

    localparam int FEED_BYTES  = 1950;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_FILE  = 6;
    localparam int HOLD_AFTER  = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_WAIT = 10;

    // Tracks the parser state and keeps the results still owed by the block.
    class anim_parse_tracker;
        typedef enum logic [3:0] {
            ST_MAGIC,
            ST_VERSION,
            ST_HEADER,
            ST_NAME_LEN,
            ST_NAME_SKIP,
            ST_SET_COUNT,
            ST_COUNT_TAG,
            ST_PAT_COUNT,
            ST_KEY,
            ST_VALUE,
            ST_DROP
        } parse_state_e;

        logic [23:0]  assembly;
        logic [1:0]   byte_pos;
        parse_state_e phase;
        logic [2:0]   key_sel;
        logic [30:0]  skip_left;
        logic [30:0]  sets_left;
        logic [30:0]  pats_left;
        logic [30:0]  set_idx;
        logic [30:0]  pat_idx;
        frame_t       frame;
        logic [31:0]  elapsed;
        result_t      step_results[$];
        result_t      awaited[$];
        int           failures;
        int           checked;

        function new();
            clear_state();
            failures = 0;
            checked  = 0;
        endfunction

        function void clear_state();
            assembly  = '0;
            byte_pos  = '0;
            phase     = ST_MAGIC;
            key_sel   = '0;
            skip_left = '0;
            sets_left = '0;
            pats_left = '0;
            set_idx   = '0;
            pat_idx   = '0;
            frame     = '0;
            elapsed   = '0;
        endfunction

        function void add_result(input logic [1:0] k, input logic [2:0] code,
                                 input bit with_frame);
            result_t r;
            if (step_results.size() >= 2)
                return;
            r = '0;
            r.kind = k;
            r.err  = code;
            if (with_frame)
            begin
                r.set_idx = set_idx;
                r.pat_idx = pat_idx;
                r.fields  = frame;
                r.elapsed = elapsed;
            end
            step_results.insert(step_results.size(), r);
        endfunction

        function void abort(input logic [2:0] code);
            add_result(KIND_ERROR, code, 0);
            phase = ST_DROP;
        endfunction

        function void open_set();
            elapsed = '0;
            phase   = ST_COUNT_TAG;
        endfunction

        function void close_set();
            sets_left = sets_left - 1'b1;
            set_idx   = set_idx + 1'b1;
            if (sets_left == 0)
            begin
                add_result(KIND_DONE, ERR_NONE, 0);
                phase = ST_DROP;
            end
            else
                open_set();
        endfunction

        function void take_word(input logic [31:0] w);
            case (phase)
                ST_MAGIC:
                    if (w != MAGIC_WORD) abort(ERR_MAGIC);
                    else phase = ST_VERSION;
                ST_VERSION:
                    if (w != VERSION_WORD) abort(ERR_VERSION);
                    else phase = ST_HEADER;
                ST_HEADER:
                    if (w == TAG_NAME) phase = ST_NAME_LEN;
                    else if (w == TAG_SETS) phase = ST_SET_COUNT;
                    else abort(ERR_HEADER);
                ST_NAME_LEN:
                    if (w[31]) abort(ERR_HEADER);
                    else if (w == 0) phase = ST_HEADER;
                    else
                    begin
                        skip_left = w[30:0];
                        phase     = ST_NAME_SKIP;
                    end
                ST_SET_COUNT:
                begin
                    set_idx = '0;
                    if (w[31] || w == 0)
                    begin
                        add_result(KIND_DONE, ERR_NONE, 0);
                        phase = ST_DROP;
                    end
                    else
                    begin
                        sets_left = w[30:0];
                        open_set();
                    end
                end
                ST_COUNT_TAG:
                    if (w != TAG_PATTERNS) abort(ERR_COUNT_TAG);
                    else phase = ST_PAT_COUNT;
                ST_PAT_COUNT:
                begin
                    pat_idx = '0;
                    frame   = '0;
                    if (w[31] || w == 0)
                        close_set();
                    else
                    begin
                        pats_left = w[30:0];
                        phase     = ST_KEY;
                    end
                end
                ST_KEY:
                    if (w == TAG_END)
                    begin
                        elapsed = elapsed + frame[WAIT_FIELD];
                        add_result(KIND_RECORD, ERR_NONE, 1);
                        frame     = '0;
                        pat_idx   = pat_idx + 1'b1;
                        pats_left = pats_left - 1'b1;
                        if (pats_left == 0)
                            close_set();
                    end
                    else if (w >= KEY_FIRST && w <= KEY_LAST)
                    begin
                        key_sel = 3'(w - KEY_FIRST);
                        phase   = ST_VALUE;
                    end
                    else
                        abort(ERR_PATTERN);
                ST_VALUE:
                begin
                    frame[key_sel] = w;
                    phase          = ST_KEY;
                end
                default: ;
            endcase
        endfunction

        // Works out the results of one accepted request; returns 1 if the byte was parsed.
        function bit accept_byte(input logic [7:0] b, input logic eof);
            bit live;
            live = (phase != ST_DROP);
            step_results.delete();
            if (phase == ST_DROP)
                ;
            else if (phase == ST_NAME_SKIP)
            begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 0)
                    phase = ST_HEADER;
            end
            else if (byte_pos < 2'd3)
            begin
                assembly[8*byte_pos +: 8] = b;
                byte_pos = byte_pos + 1'b1;
            end
            else
            begin
                byte_pos = '0;
                take_word({b, assembly});
                assembly = '0;
            end
            if (eof)
            begin
                if (phase != ST_DROP)
                    add_result(KIND_ERROR, ERR_TRUNCATED, 0);
                clear_state();
            end
            if (step_results.size() > 0)
                step_results[step_results.size()-1].last = 1'b1;
            foreach (step_results[i])
                awaited.insert(awaited.size(), step_results[i]);
            return live;
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            checked++;
            if (awaited.size() == 0)
            begin
                $error("result with kind %0d arrived with nothing outstanding", got.kind);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("error_code", 32'(want.err), 32'(got.err));
            compare_field("set_index", 32'(want.set_idx), 32'(got.set_idx));
            compare_field("pattern_index", 32'(want.pat_idx), 32'(got.pat_idx));
            compare_field("pattern_number", want.fields[0], got.fields[0]);
            compare_field("pos_x", want.fields[1], got.fields[1]);
            compare_field("pos_y", want.fields[2], got.fields[2]);
            compare_field("wait_time", want.fields[3], got.fields[3]);
            compare_field("blend_value", want.fields[4], got.fields[4]);
            compare_field("depth_z", want.fields[5], got.fields[5]);
            compare_field("elapsed_time", want.elapsed, got.elapsed);
            compare_field("last_in_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               end_of_file;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         kind;
    logic [2:0]         error_code;
    logic [30:0]        set_index;
    logic [30:0]        pattern_index;
    logic signed [31:0] pattern_number;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] wait_time;
    logic signed [31:0] blend_value;
    logic signed [31:0] depth_z;
    logic signed [31:0] elapsed_time;
    logic               last_in_run;

    anim_parse_tracker sb = new();
    logic [7:0]        file_bytes[$];
    int                fed_bytes = 0;
    int                cycle_count = 0;
    bit                steady_feed = 0;

    tagged_animation_record_parser_unit i_dut (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_tagged_animation_record_parser_unit NOT OK");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Appends one byte to the file under construction.
    function automatic void add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            add_byte(w[8*i +: 8]);
    endfunction

    // A count word: zero, negative, very large, or a small positive number.
    function automatic logic [31:0] pick_count(input int top, input bit allow_big);
        int z;
        z = $urandom_range(0, 19);
        if (z == 0) return 32'h0;
        if (z == 1) return 32'h8000_0000 | $urandom;
        if (z == 2 && allow_big) return 32'h7fff_fff0 + $urandom_range(0, 15);
        return $urandom_range(1, top);
    endfunction

    // Builds one file: mostly well formed with random content, some damaged, some noise.
    function automatic void build_file();
        int          r;
        int          n_sets;
        int          n_pats;
        int          idx;
        int          cut;
        logic [31:0] w;
        file_bytes.delete();
        r = $urandom_range(0, 99);
        if (r >= 93)
        begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
            return;
        end
        put_word(($urandom_range(0, 30) == 0) ? rand_word() : MAGIC_WORD);
        put_word(($urandom_range(0, 20) == 0) ? rand_word() : VERSION_WORD);
        repeat ($urandom_range(0, 2))
        begin
            put_word(TAG_NAME);
            case ($urandom_range(0, 9))
                0, 1: w = 32'h0;
                2: w = 32'h8000_0000 | $urandom;
                default: w = $urandom_range(1, 6);
            endcase
            put_word(w);
            if (!w[31])
                repeat (w) add_byte(8'($urandom));
        end
        put_word(($urandom_range(0, 20) == 0) ? rand_word() : TAG_SETS);
        w = pick_count(2, 1);
        put_word(w);
        n_sets = w[31] ? 0 : ((w > 2) ? $urandom_range(1, 2) : int'(w));
        repeat (n_sets)
        begin
            put_word(($urandom_range(0, 20) == 0) ? rand_word() : TAG_PATTERNS);
            w = pick_count(2, 0);
            put_word(w);
            n_pats = w[31] ? 0 : int'(w);
            repeat (n_pats)
            begin
                repeat ($urandom_range(0, 4))
                begin
                    put_word(($urandom_range(0, 40) == 0) ? rand_word()
                                                         : KEY_FIRST + $urandom_range(0, 5));
                    put_word(rand_word());
                end
                put_word(TAG_END);
            end
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        // Damage: cut the file short, or flip one bit somewhere.
        if (r >= 85)
        begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
        else if (r >= 70)
        begin
            idx = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
        end
    endfunction

    // Offers one request and waits until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = pick_gap(steady_feed);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        void'(sb.accept_byte(b, eof));
        fed_bytes++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Stops offering until every outstanding result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.awaited.size() != 0);
    endtask

    // Sender.
    initial
    begin
        int file_no;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= 8'h00;
        end_of_file <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone final byte: truncated right at the start.
        file_bytes.delete();
        add_byte(8'hff);
        send_file();
        // Bad magic word.
        file_bytes.delete();
        put_word(32'h0);
        send_file();
        // Set count of zero finishes at once; the trailing byte is ignored.
        file_bytes.delete();
        put_word(MAGIC_WORD);
        put_word(VERSION_WORD);
        put_word(TAG_SETS);
        put_word(32'h0);
        add_byte(8'h5a);
        send_file();

        file_no = 0;
        while (fed_bytes < FEED_BYTES)
        begin
            steady_feed = ($urandom_range(0, 4) == 0);
            build_file();
            send_file();
            file_no++;
            if (file_no == DRAIN_FILE)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (sb.failures == 0)
            $display("tb_tagged_animation_record_parser_unit OK");
        else
            $display("tb_tagged_animation_record_parser_unit NOT OK");
        $finish;
    end

    // Receiver: random stalls, once a long hold-off so the result queue backs up.
    initial
    begin
        int hold;
        int run;
        bit long_done;
        long_done = 0;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = pick_gap(0);
            // The long hold-off starts while the sender is offering requests.
            if (!long_done && sb.checked >= HOLD_AFTER && in_valid === 1'b1)
            begin
                hold      = HOLD_CYCLES;
                long_done = 1;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
        end
    end

    // Result monitor.
    initial
    begin
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            begin
                got           = '0;
                got.kind      = kind;
                got.err       = error_code;
                got.set_idx   = set_index;
                got.pat_idx   = pattern_index;
                got.fields[0] = pattern_number;
                got.fields[1] = pos_x;
                got.fields[2] = pos_y;
                got.fields[3] = wait_time;
                got.fields[4] = blend_value;
                got.fields[5] = depth_z;
                got.elapsed   = elapsed_time;
                got.last      = last_in_run;
                sb.check_result(got);
            end
        end
    end

endmodule

`default_nettype wire

>>> sim.f
src/tarp_pkg.sv
src/tagged_animation_record_parser_unit.sv
src/tarp_checker.sv
sim/tb_tagged_animation_record_parser_unit.sv
